FILE: src/spherical_offset_bin_classifier_unit_macros.svh
// Assertion helpers used by the bound checker module.
`ifndef SPHERICAL_OFFSET_BIN_CLASSIFIER_UNIT_MACROS_SVH
`define SPHERICAL_OFFSET_BIN_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SOBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SOBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sobc_pkg.sv
package sobc_pkg;

  // Item layout
  localparam int NUM_IN_FIELDS = 7;
  localparam int BIN_W         = 7;
  localparam int OUT_TDATA_W   = 8;
  localparam int RING_W        = 2;
  localparam int SECTOR_W      = 3;

  // Ring codes
  localparam logic [RING_W-1:0] RING_INNER = 2'd0;
  localparam logic [RING_W-1:0] RING_MID   = 2'd1;
  localparam logic [RING_W-1:0] RING_OUTER = 2'd2;
  localparam logic [RING_W-1:0] RING_OVER  = 2'd3;

  // Per-stage load enables handed to the ring datapath
  typedef struct packed {
    logic sq;
    logic sum;
  } stage_en_t;

  // Pick the 45 degree azimuth slice from signs and |y| against |x|.
  function automatic logic [SECTOR_W-1:0] sector_of(
    input logic x_neg,
    input logic x_pos,
    input logic y_neg,
    input logic y_pos,
    input logic y_lt_x,
    input logic y_gt_x
  );
    logic [SECTOR_W-1:0] s;
    if (y_neg) begin
      if (x_neg) s = y_lt_x ? 3'd0 : 3'd1;
      else       s = y_gt_x ? 3'd2 : 3'd3;
    end else if (x_pos) begin
      s = y_lt_x ? 3'd4 : 3'd5;
    end else if (x_neg) begin
      s = y_gt_x ? 3'd6 : 3'd7;
    end else begin
      // on the z axis or straight along +y
      s = y_pos ? 3'd6 : 3'd4;
    end
    return s;
  endfunction

endpackage

FILE: src/sobc_ring_pipe.sv
module sobc_ring_pipe #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  sobc_pkg::stage_en_t           en_i,
  input  logic [COORD_BITS:0]           ax_i,
  input  logic [COORD_BITS:0]           ay_i,
  input  logic [COORD_BITS:0]           az_i,
  input  logic [COORD_BITS-1:0]         rad_i,
  output logic [sobc_pkg::RING_W-1:0]   ring_o
);

  localparam int MAG_W  = COORD_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int X9_W   = SUM_W + 4;
  localparam int RAD2_W = 2 * COORD_BITS;

  logic [SQ_W-1:0]   sq_x_d, sq_x_q;
  logic [SQ_W-1:0]   sq_y_d, sq_y_q;
  logic [SQ_W-1:0]   sq_z_d, sq_z_q;
  logic [RAD2_W-1:0] rad2_d, rad2_q;
  logic [SUM_W-1:0]  r2_d, r2_q;
  logic [RAD2_W-1:0] rad2_s4_q;
  logic [X9_W-1:0]   r2x9;
  logic [X9_W-1:0]   big1;
  logic [X9_W-1:0]   big4;

  // Square the magnitudes and the radius
  assign sq_x_d = ax_i * ax_i;
  assign sq_y_d = ay_i * ay_i;
  assign sq_z_d = az_i * az_i;
  assign rad2_d = rad_i * rad_i;

  always_ff @(posedge clk_i) begin
    if (en_i.sq) begin
      sq_x_q <= sq_x_d;
      sq_y_q <= sq_y_d;
      sq_z_q <= sq_z_d;
      rad2_q <= rad2_d;
    end
  end

  // Add up the squared offset
  assign r2_d = SUM_W'(sq_x_q) + SUM_W'(sq_y_q) + SUM_W'(sq_z_q);

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      r2_q      <= r2_d;
      rad2_s4_q <= rad2_q;
    end
  end

  // Compare 9r^2 and r^2 against R^2 and 4R^2; ties go outward
  assign r2x9 = (X9_W'(r2_q) << 3) + X9_W'(r2_q);
  assign big1 = X9_W'(rad2_s4_q);
  assign big4 = X9_W'(rad2_s4_q) << 2;

  always_comb begin
    if (r2x9 < big1)             ring_o = sobc_pkg::RING_INNER;
    else if (r2x9 < big4)        ring_o = sobc_pkg::RING_MID;
    else if (X9_W'(r2_q) < big4) ring_o = sobc_pkg::RING_OUTER;
    else                         ring_o = sobc_pkg::RING_OVER;
  end

endmodule

FILE: src/spherical_offset_bin_classifier_unit.sv
// Spherical offset bin classifier.
// Input stream: one beat per center/neighbor pair with its normalizing radius.
// Output stream: one beat per input beat, in order, carrying the bin number
// (0 for a zero offset, else ring*16 + hemisphere*8 + sector + 1).
// Pipeline: difference, magnitude/sector, squares, sum, compare into the
// output register. Throughput is one beat per cycle while the receiver keeps
// m_axis_tready_i high; the rate is set by the five register stages, each
// of which takes a new beat every cycle when it is enabled to advance.
// Each stage advances when it is empty or the stage after it advances, so
// a stalled receiver holds the output beat while upstream bubbles fill in;
// s_axis_tready_o drops only once every stage holds a beat.
// Reset clears all valid bits: no output beat is shown and input is ready
// from the first cycle after reset.
module spherical_offset_bin_classifier_unit #(
  parameter int COORD_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // center_x, center_y, center_z, target_x, target_y, target_z, norm_radius
  input  logic [((sobc_pkg::NUM_IN_FIELDS*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // bin_id, zero pad
  output logic [sobc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int N     = COORD_BITS;
  localparam int MAG_W = COORD_BITS + 1;

  logic [N-1:0] center_x, center_y, center_z;
  logic [N-1:0] target_x, target_y, target_z;
  logic [N-1:0] norm_radius;

  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic en1, en2, en3, en4, en_out;

  logic [MAG_W-1:0] dx_d, dx_q, dy_d, dy_q, dz_d, dz_q;
  logic [N-1:0]     rad_s1_q, rad_s2_q;

  logic [MAG_W-1:0] ax_d, ax_q, ay_d, ay_q, az_d, az_q;
  logic             zero_d, zero_s2_q, zero_s3_q, zero_s4_q;
  logic             hemi_d, hemi_s2_q, hemi_s3_q, hemi_s4_q;
  logic [sobc_pkg::SECTOR_W-1:0] sect_d, sect_s2_q, sect_s3_q, sect_s4_q;

  logic [sobc_pkg::RING_W-1:0] ring;
  logic [sobc_pkg::BIN_W-1:0]  bin_d, bin_q;
  sobc_pkg::stage_en_t         ring_en;

  // Unpack input fields, lowest first
  assign center_x    = s_axis_tdata_i[0*N +: N];
  assign center_y    = s_axis_tdata_i[1*N +: N];
  assign center_z    = s_axis_tdata_i[2*N +: N];
  assign target_x    = s_axis_tdata_i[3*N +: N];
  assign target_y    = s_axis_tdata_i[4*N +: N];
  assign target_z    = s_axis_tdata_i[5*N +: N];
  assign norm_radius = s_axis_tdata_i[6*N +: N];

  // Stage enables: advance when empty or when the next stage advances
  assign en_out = !out_v_q || m_axis_tready_i;
  assign en4    = !v4_q || en_out;
  assign en3    = !v3_q || en4;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    v1_q    <= s_axis_tvalid_i;
      if (en2)    v2_q    <= v1_q;
      if (en3)    v3_q    <= v2_q;
      if (en4)    v4_q    <= v3_q;
      if (en_out) out_v_q <= v4_q;
    end
  end

  // Stage 1: offsets, sign-extended by one bit
  assign dx_d = {target_x[N-1], target_x} - {center_x[N-1], center_x};
  assign dy_d = {target_y[N-1], target_y} - {center_y[N-1], center_y};
  assign dz_d = {target_z[N-1], target_z} - {center_z[N-1], center_z};

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      dz_q     <= dz_d;
      rad_s1_q <= norm_radius;
    end
  end

  // Stage 2: magnitudes, self test, hemisphere and azimuth slice
  assign ax_d   = dx_q[N] ? (~dx_q + MAG_W'(1)) : dx_q;
  assign ay_d   = dy_q[N] ? (~dy_q + MAG_W'(1)) : dy_q;
  assign az_d   = dz_q[N] ? (~dz_q + MAG_W'(1)) : dz_q;
  assign zero_d = (dx_q == '0) && (dy_q == '0) && (dz_q == '0);
  assign hemi_d = !dz_q[N];
  assign sect_d = sobc_pkg::sector_of(dx_q[N], !dx_q[N] && (dx_q != '0),
                                      dy_q[N], !dy_q[N] && (dy_q != '0),
                                      ay_d < ax_d, ay_d > ax_d);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ax_q      <= ax_d;
      ay_q      <= ay_d;
      az_q      <= az_d;
      rad_s2_q  <= rad_s1_q;
      zero_s2_q <= zero_d;
      hemi_s2_q <= hemi_d;
      sect_s2_q <= sect_d;
    end
  end

  // Stages 3 and 4: carry the side bits along the ring datapath
  always_ff @(posedge clk_i) begin
    if (en3) begin
      zero_s3_q <= zero_s2_q;
      hemi_s3_q <= hemi_s2_q;
      sect_s3_q <= sect_s2_q;
    end
    if (en4) begin
      zero_s4_q <= zero_s3_q;
      hemi_s4_q <= hemi_s3_q;
      sect_s4_q <= sect_s3_q;
    end
  end

  assign ring_en.sq  = en3;
  assign ring_en.sum = en4;

  sobc_ring_pipe #(
    .COORD_BITS(COORD_BITS)
  ) u_ring (
    .clk_i (clk_i),
    .en_i  (ring_en),
    .ax_i  (ax_q),
    .ay_i  (ay_q),
    .az_i  (az_q),
    .rad_i (rad_s2_q),
    .ring_o(ring)
  );

  // Output register: bin number
  assign bin_d = zero_s4_q ? '0
               : ({1'b0, ring, hemi_s4_q, sect_s4_q} + sobc_pkg::BIN_W'(1));

  always_ff @(posedge clk_i) begin
    if (en_out) bin_q <= bin_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(sobc_pkg::OUT_TDATA_W - sobc_pkg::BIN_W){1'b0}}, bin_q};

endmodule

FILE: src/sobc_checker.sv
`include "spherical_offset_bin_classifier_unit_macros.svh"

module sobc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [sobc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // Bin numbers never pass the last spherical bin
  `SOBC_ASSERT_NOW(a_bin_range, m_axis_tvalid_o, m_axis_tdata_o[6:0] <= 7'd64, "bin out of range")

  // Padding above the bin stays clear
  `SOBC_ASSERT_NOW(a_pad_zero, m_axis_tvalid_o, m_axis_tdata_o[7] == 1'b0, "tdata pad set")

  // An empty output stage means the pipeline can take a beat
  `SOBC_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid_o, s_axis_tready_o, "ready low while drained")

  // A stalled output beat holds
  `SOBC_ASSERT_NEXT(a_hold_stall, m_axis_tvalid_o && !m_axis_tready_i,
                    m_axis_tvalid_o && $stable(m_axis_tdata_o), "output beat dropped")

endmodule

bind spherical_offset_bin_classifier_unit sobc_checker u_sobc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

FILE: bench/spherical_offset_bin_classifier_unit_checker.sv
`timescale 1ns / 100ps

// Watch both streams, predict the bin of every accepted pair and compare it
// against the output beats in order.
module spherical_offset_bin_classifier_unit_checker #(
  parameter int COORD_BITS = 24,
  parameter int IN_W       = ((sobc_pkg::NUM_IN_FIELDS*COORD_BITS+7)/8)*8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  // center_x, center_y, center_z, target_x, target_y, target_z, norm_radius
  input  logic [IN_W-1:0]                  s_axis_tdata_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  // bin_id, zero pad
  input  logic [sobc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      pending_o
);

  localparam int BIN_W = sobc_pkg::BIN_W;

  // Field positions inside the input beat
  localparam int FLD_CENTER_X = 0;
  localparam int FLD_CENTER_Y = 1;
  localparam int FLD_CENTER_Z = 2;
  localparam int FLD_TARGET_X = 3;
  localparam int FLD_TARGET_Y = 4;
  localparam int FLD_TARGET_Z = 5;
  localparam int FLD_RADIUS   = 6;

  localparam int unsigned REPORT_LIMIT = 10;

  logic [BIN_W-1:0] expected_bins[$];
  int unsigned      bin_errors = 0;
  int unsigned      pending_q;

  assign mismatch_count_o = bin_errors;
  assign pending_o        = pending_q;

  // Pull one signed coordinate out of a beat
  function automatic longint coord_at(input logic [IN_W-1:0] beat, input int idx);
    logic [COORD_BITS-1:0] raw;
    raw = beat[idx*COORD_BITS +: COORD_BITS];
    return longint'($signed(raw));
  endfunction

  // Azimuth slice of the (x, y) offset; boundaries go to the higher slice
  function automatic logic [sobc_pkg::SECTOR_W-1:0] azimuth_slice(
    input longint dx,
    input longint dy
  );
    longint ax;
    longint ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (dy < 0) begin
      if (dx < 0) return (ay < ax) ? 3'd0 : 3'd1;
      return (ay > ax) ? 3'd2 : 3'd3;
    end
    if (dx > 0) return (ay < ax) ? 3'd4 : 3'd5;
    if (dx < 0) return (ay <= ax) ? 3'd7 : 3'd6;
    return (dy > 0) ? 3'd6 : 3'd4;
  endfunction

  // Bin of one center/neighbor pair, from exact comparisons of squares
  function automatic logic [BIN_W-1:0] classify_offset(input logic [IN_W-1:0] beat);
    longint                      dx;
    longint                      dy;
    longint                      dz;
    longint                      radius;
    longint                      dist2;
    longint                      rad2;
    logic [sobc_pkg::RING_W-1:0] ring;
    logic                        upper;
    int                          code;
    dx = coord_at(beat, FLD_TARGET_X) - coord_at(beat, FLD_CENTER_X);
    dy = coord_at(beat, FLD_TARGET_Y) - coord_at(beat, FLD_CENTER_Y);
    dz = coord_at(beat, FLD_TARGET_Z) - coord_at(beat, FLD_CENTER_Z);
    radius = longint'(beat[FLD_RADIUS*COORD_BITS +: COORD_BITS]);
    if (dx == 0 && dy == 0 && dz == 0) return '0;
    dist2 = dx*dx + dy*dy + dz*dz;
    rad2  = radius*radius;
    if (9*dist2 < rad2)          ring = sobc_pkg::RING_INNER;
    else if (9*dist2 < 4*rad2)   ring = sobc_pkg::RING_MID;
    else if (dist2 < 4*rad2)     ring = sobc_pkg::RING_OUTER;
    else                         ring = sobc_pkg::RING_OVER;
    upper = (dz >= 0);
    code  = int'(ring)*16 + int'(upper)*8 + int'(azimuth_slice(dx, dy)) + 1;
    return code[BIN_W-1:0];
  endfunction

  // Compare output beats first, then queue the prediction for a new pair
  always @(posedge clk_i or negedge rst_ni) begin : track_bins
    logic [BIN_W-1:0] want;
    if (!rst_ni) begin
      expected_bins.delete();
      pending_q <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_bins.size() == 0) begin
          if (bin_errors < REPORT_LIMIT)
            $display("unexpected bin beat: got %0d with nothing pending",
                     m_axis_tdata_i[BIN_W-1:0]);
          bin_errors++;
        end else begin
          want = expected_bins.pop_front();
          if (m_axis_tdata_i[BIN_W-1:0] !== want) begin
            if (bin_errors < REPORT_LIMIT)
              $display("bin mismatch: expected %0d, got %0d",
                       want, m_axis_tdata_i[BIN_W-1:0]);
            bin_errors++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_bins.insert(expected_bins.size(), classify_offset(s_axis_tdata_i));
      pending_q <= expected_bins.size();
    end
  end

endmodule

FILE: bench/spherical_offset_bin_classifier_unit_tb.sv
`timescale 1ns / 100ps

module spherical_offset_bin_classifier_unit_tb;

  localparam int          COORD_BITS       = 24;
  localparam int          IN_W             = ((sobc_pkg::NUM_IN_FIELDS*COORD_BITS+7)/8)*8;
  localparam int          COORD_MIN        = -(2 ** (COORD_BITS-1));
  localparam int          COORD_MAX        = 2 ** (COORD_BITS-1) - 1;
  localparam int          RAD_MAX          = 2 ** COORD_BITS - 1;
  localparam int          PAIRS_PER_PHASE  = 330;
  localparam int          NUM_PHASES       = 4;
  localparam int          SETTLE_CYCLES    = 20;
  localparam int unsigned CYCLE_LIMIT      = 200000;

  typedef struct {
    int cx;
    int cy;
    int cz;
    int tx;
    int ty;
    int tz;
    int rad;
  } point_pair_t;

  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [IN_W-1:0]                  s_axis_tdata_i  = '0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [sobc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  int unsigned mismatch_count;
  int unsigned pending_bins;
  int unsigned cycle_count = 0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;

  spherical_offset_bin_classifier_unit #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  spherical_offset_bin_classifier_unit_checker #(
    .COORD_BITS(COORD_BITS),
    .IN_W      (IN_W)
  ) bin_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_bins)
  );

  always #10 clk_i = ~clk_i;

  // Stall the output side at the current phase's rate
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_pair(input point_pair_t p);
    logic [IN_W-1:0] beat;
    beat = '0;
    beat[0*COORD_BITS +: COORD_BITS] = p.cx[COORD_BITS-1:0];
    beat[1*COORD_BITS +: COORD_BITS] = p.cy[COORD_BITS-1:0];
    beat[2*COORD_BITS +: COORD_BITS] = p.cz[COORD_BITS-1:0];
    beat[3*COORD_BITS +: COORD_BITS] = p.tx[COORD_BITS-1:0];
    beat[4*COORD_BITS +: COORD_BITS] = p.ty[COORD_BITS-1:0];
    beat[5*COORD_BITS +: COORD_BITS] = p.tz[COORD_BITS-1:0];
    beat[6*COORD_BITS +: COORD_BITS] = p.rad[COORD_BITS-1:0];
    return beat;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(RAD_MAX)) + COORD_MIN;
  endfunction

  function automatic int random_sign(input int m);
    return $urandom_range(1) ? m : -m;
  endfunction

  // Center such that center + d stays inside the coordinate range
  function automatic int center_for(input int d);
    int lo;
    int hi;
    lo = (d < 0) ? COORD_MIN - d : COORD_MIN;
    hi = (d > 0) ? COORD_MAX - d : COORD_MAX;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Present one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [IN_W-1:0] beat);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= beat;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_pair(input int cx, input int cy, input int cz,
                           input int tx, input int ty, input int tz, input int rad);
    point_pair_t p;
    p = '{cx, cy, cz, tx, ty, tz, rad};
    send_beat(pack_pair(p));
  endtask

  // Send an offset from a randomly placed center
  task automatic send_offset(input int dx, input int dy, input int dz, input int rad);
    int cx;
    int cy;
    int cz;
    cx = center_for(dx);
    cy = center_for(dy);
    cz = center_for(dz);
    send_pair(cx, cy, cz, cx + dx, cy + dy, cz + dz, rad);
  endtask

  // Hold the input idle until every queued bin has come out
  task automatic drain_bins();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_bins != 0);
  endtask

  task automatic send_random_pair();
    int pick;
    int m;
    int a;
    int len;
    int dx;
    int dy;
    int dz;
    int tmp;
    int rad;
    int c;
    pick = $urandom_range(99);
    if (pick < 3) begin
      // zero offset anywhere
      c = any_coord();
      dx = any_coord();
      dy = any_coord();
      send_pair(c, dx, dy, c, dx, dy, $urandom_range(RAD_MAX, 1));
    end else if (pick < 18) begin
      // raw fields, every bit free
      send_pair(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                any_coord(), $urandom_range(RAD_MAX, 1));
    end else if (pick < 70) begin
      // offsets at a random scale, radius on a comparable scale
      m  = 1 << $urandom_range(22);
      dx = ($urandom_range(7) == 0) ? 0 : random_sign($urandom_range(m));
      dy = ($urandom_range(7) == 0) ? 0 : random_sign($urandom_range(m));
      dz = ($urandom_range(7) == 0) ? 0 : random_sign($urandom_range(m));
      rad = (6*m + 1 > RAD_MAX) ? RAD_MAX : 6*m + 1;
      send_offset(dx, dy, dz, $urandom_range(rad, 1));
    end else if (pick < 88) begin
      // integer-length offsets placed exactly on, or next to, a ring edge
      a = 2 * int'($urandom_range(1 << $urandom_range(18), 1));
      case ($urandom_range(3))
        0: begin dx = a;   dy = 0;   dz = 0;   len = 1; end
        1: begin dx = 3*a; dy = 4*a; dz = 0;   len = 5; end
        2: begin dx = a;   dy = 2*a; dz = 2*a; len = 3; end
        default: begin dx = 2*a; dy = 3*a; dz = 6*a; len = 7; end
      endcase
      if ($urandom_range(1)) begin tmp = dx; dx = dz; dz = tmp; end
      if ($urandom_range(1)) begin tmp = dy; dy = dz; dz = tmp; end
      if ($urandom_range(1)) begin tmp = dx; dx = dy; dy = tmp; end
      case ($urandom_range(2))
        0:       rad = 3 * len * a;
        1:       rad = 3 * len * a / 2;
        default: rad = len * a / 2;
      endcase
      rad = rad + int'($urandom_range(2)) - 1;
      if (rad < 1) rad = 1;
      send_offset(random_sign(dx), random_sign(dy), random_sign(dz), rad);
    end else begin
      // offsets on or next to the diagonal and axis slice edges
      a  = $urandom_range(1 << $urandom_range(20), 1);
      dx = ($urandom_range(4) == 0) ? 0 : random_sign(a);
      case ($urandom_range(3))
        0:       dy = 0;
        1:       dy = a;
        2:       dy = a - 1;
        default: dy = a + 1;
      endcase
      dy = random_sign(dy);
      dz = ($urandom_range(2) == 0) ? 0 : random_sign($urandom_range(a));
      send_offset(dx, dy, dz, $urandom_range(4*a + 1, 1));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: self, zero radius, field extremes
    send_pair(5, -9, 12, 5, -9, 12, 5);
    send_pair(COORD_MIN, COORD_MAX, 0, COORD_MIN, COORD_MAX, 0, 0);
    send_pair(0, 0, 0, 1, 0, 0, 0);
    send_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX);
    send_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 1);
    send_pair(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, RAD_MAX);
    // Directed: z axis, the four half axes, the four diagonals
    send_offset(0, 0, 5, 100);
    send_offset(0, 0, -5, 100);
    send_offset(7, 0, 0, 100);
    send_offset(0, 7, 0, 100);
    send_offset(-7, 0, 3, 100);
    send_offset(0, -7, -3, 100);
    send_offset(9, 9, 1, 40);
    send_offset(-9, 9, -1, 40);
    send_offset(-9, -9, 1, 40);
    send_offset(9, -9, -1, 40);
    // Directed: ring edges exactly and just inside
    send_offset(1, 0, 0, 3);
    send_offset(1, 0, 0, 4);
    send_offset(2, 0, 0, 3);
    send_offset(2, 0, 0, 4);
    send_offset(2, 0, 0, 1);
    send_offset(2, 0, 0, 2);
    send_offset(3, 4, 0, 15);
    send_offset(3, 1, 0, 1000);
    drain_bins();

    // Random pairs over the idle and stall phases, draining after each phase
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 74; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      repeat (PAIRS_PER_PHASE) send_random_pair();
      drain_bins();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
